// ----- sv/xte_pkg.sv -----
// xte_pkg: shared types and constants for the xml text escaper pipeline
// no dependencies; used by every xte module and by xml_text_escaper_core
package xte_pkg;

   // longest output run: &#DDD; plus a zero terminator
   localparam int unsigned SEQ_LEN = 7;
   localparam int unsigned CNT_W   = 3;

   typedef enum logic [2:0] {
      KIND_TERM,
      KIND_QUOT,
      KIND_LT,
      KIND_GT,
      KIND_AMP,
      KIND_PLAIN,
      KIND_NUM,
      KIND_BAD
   } kind_type;

   // classified byte, leaving the classify stage
   typedef struct packed {
      kind_type   kind;
      logic [7:0] src_byte;
      logic [1:0] hund;
      logic [6:0] rem;
      logic       fin;
   } cls_type;

   // fully expanded character run, leaving the expand stage
   typedef struct packed {
      logic [SEQ_LEN-1:0][7:0] chars;
      logic [CNT_W-1:0]        cnt;
      logic                    bad;
   } seq_type;

endpackage

// ----- sv/xte_classify.sv -----
// xte_classify: input register and byte classification stage
// depends on xte_pkg
module xte_classify (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   output logic             cls_valid,
   input  logic             cls_ready,
   output xte_pkg::cls_type cls_data
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_fin_ff;
   logic             cls_valid_ff, cls_valid_in;
   xte_pkg::cls_type cls_ff, cls_in;
   logic             cls_take;
   logic             in_take;

   assign cls_take   = !cls_valid_ff || cls_ready;
   assign in_take    = !in_valid_ff || cls_take;
   assign req_tready = in_take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_take) begin
         in_valid_in = req_tvalid;
      end
   end

   always_comb begin
      cls_valid_in = cls_valid_ff;
      if (cls_take) begin
         cls_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      cls_in          = '0;
      cls_in.src_byte = in_byte_ff;
      cls_in.fin      = in_fin_ff;
      if (in_byte_ff == 8'd0) begin
         cls_in.kind = xte_pkg::KIND_TERM;
      end else if (in_byte_ff == "\"") begin
         cls_in.kind = xte_pkg::KIND_QUOT;
      end else if (in_byte_ff == "<") begin
         cls_in.kind = xte_pkg::KIND_LT;
      end else if (in_byte_ff == ">") begin
         cls_in.kind = xte_pkg::KIND_GT;
      end else if (in_byte_ff == "&") begin
         cls_in.kind = xte_pkg::KIND_AMP;
      end else if (in_byte_ff > 8'd31 && in_byte_ff < 8'd127) begin
         cls_in.kind = xte_pkg::KIND_PLAIN;
      end else if (in_byte_ff >= 8'd127 || in_byte_ff == 8'd9 ||
                   in_byte_ff == 8'd10 || in_byte_ff == 8'd13) begin
         cls_in.kind = xte_pkg::KIND_NUM;
      end else begin
         cls_in.kind = xte_pkg::KIND_BAD;
      end
      // hundreds digit by compare, remainder kept below 100
      if (in_byte_ff >= 8'd200) begin
         cls_in.hund = 2'd2;
         cls_in.rem  = 7'(in_byte_ff - 8'd200);
      end else if (in_byte_ff >= 8'd100) begin
         cls_in.hund = 2'd1;
         cls_in.rem  = 7'(in_byte_ff - 8'd100);
      end else begin
         cls_in.hund = 2'd0;
         cls_in.rem  = in_byte_ff[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         cls_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         cls_valid_ff <= cls_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_byte_ff <= req_tdata;
         in_fin_ff  <= req_tlast;
      end
      if (cls_take) begin
         cls_ff <= cls_in;
      end
   end

   assign cls_valid = cls_valid_ff;
   assign cls_data  = cls_ff;

endmodule

// ----- sv/xte_expand.sv -----
// xte_expand: turns a classified byte into its escaped character run
// depends on xte_pkg
module xte_expand (
   input  logic             clock,
   input  logic             reset,
   input  logic             cls_valid,
   output logic             cls_ready,
   input  xte_pkg::cls_type cls_data,
   output logic             seq_valid,
   input  logic             seq_ready,
   output xte_pkg::seq_type seq_data
);

   logic             seq_valid_ff, seq_valid_in;
   xte_pkg::seq_type seq_ff, seq_in;
   logic             take;
   logic [14:0]      tens_prod;
   logic [3:0]       tens;
   logic [3:0]       ones;

   assign take      = !seq_valid_ff || seq_ready;
   assign cls_ready = take;

   // rem / 10 by reciprocal, exact for rem below 100
   assign tens_prod = 15'(cls_data.rem) * 15'd205;
   assign tens      = tens_prod[14:11];
   assign ones      = 4'(cls_data.rem - 7'(tens) * 7'd10);

   always_comb begin
      seq_valid_in = seq_valid_ff;
      if (take) begin
         seq_valid_in = cls_valid;
      end
   end

   always_comb begin
      seq_in     = '0;
      seq_in.bad = (cls_data.kind == xte_pkg::KIND_BAD);
      unique case (cls_data.kind)
         xte_pkg::KIND_TERM: begin
            seq_in.cnt = 3'd1;
         end
         xte_pkg::KIND_QUOT: begin
            seq_in.chars[0] = "&";
            seq_in.chars[1] = "q";
            seq_in.chars[2] = "u";
            seq_in.chars[3] = "o";
            seq_in.chars[4] = "t";
            seq_in.chars[5] = ";";
            seq_in.cnt      = 3'd6;
         end
         xte_pkg::KIND_LT: begin
            seq_in.chars[0] = "&";
            seq_in.chars[1] = "l";
            seq_in.chars[2] = "t";
            seq_in.chars[3] = ";";
            seq_in.cnt      = 3'd4;
         end
         xte_pkg::KIND_GT: begin
            seq_in.chars[0] = "&";
            seq_in.chars[1] = "g";
            seq_in.chars[2] = "t";
            seq_in.chars[3] = ";";
            seq_in.cnt      = 3'd4;
         end
         xte_pkg::KIND_AMP: begin
            seq_in.chars[0] = "&";
            seq_in.chars[1] = "a";
            seq_in.chars[2] = "m";
            seq_in.chars[3] = "p";
            seq_in.chars[4] = ";";
            seq_in.cnt      = 3'd5;
         end
         xte_pkg::KIND_PLAIN: begin
            seq_in.chars[0] = cls_data.src_byte;
            seq_in.cnt      = 3'd1;
         end
         xte_pkg::KIND_NUM: begin
            seq_in.chars[0] = "&";
            seq_in.chars[1] = "#";
            seq_in.chars[2] = "0" + 8'(cls_data.hund);
            seq_in.chars[3] = "0" + 8'(tens);
            seq_in.chars[4] = "0" + 8'(ones);
            seq_in.chars[5] = ";";
            seq_in.cnt      = 3'd6;
         end
         xte_pkg::KIND_BAD: begin
            seq_in.chars[0] = "?";
            seq_in.cnt      = 3'd1;
         end
         default: begin
            seq_in.cnt = 3'd1;
         end
      endcase
      // unused slots are zero, so the terminator only widens the run
      if (cls_data.fin && cls_data.kind != xte_pkg::KIND_TERM) begin
         seq_in.cnt = seq_in.cnt + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_valid_ff <= 1'b0;
      end else begin
         seq_valid_ff <= seq_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         seq_ff <= seq_in;
      end
   end

   assign seq_valid = seq_valid_ff;
   assign seq_data  = seq_ff;

endmodule

// ----- sv/xte_serial.sv -----
// xte_serial: output buffer that sends one character of a run per transfer
// depends on xte_pkg
module xte_serial (
   input  logic             clock,
   input  logic             reset,
   input  logic             seq_valid,
   output logic             seq_ready,
   input  xte_pkg::seq_type seq_data,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tuser
);

   logic [xte_pkg::SEQ_LEN-1:0][7:0] buf_ff, buf_in;
   logic [xte_pkg::CNT_W-1:0]        left_ff, left_in;
   logic                             bad_ff, bad_in;
   logic                             load;
   logic                             sent;

   assign rsp_tvalid = (left_ff != '0);
   assign sent       = rsp_tvalid && rsp_tready;
   // a new run may load while the last character of the current one goes out
   assign seq_ready  = (left_ff == '0) || (sent && left_ff == 3'd1);
   assign load       = seq_valid && seq_ready;

   always_comb begin
      buf_in  = buf_ff;
      left_in = left_ff;
      bad_in  = bad_ff;
      if (load) begin
         buf_in  = seq_data.chars;
         left_in = seq_data.cnt;
         bad_in  = seq_data.bad;
      end else if (sent) begin
         buf_in  = {8'd0, buf_ff[xte_pkg::SEQ_LEN-1:1]};
         left_in = left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      bad_ff <= bad_in;
   end

   assign rsp_tdata = buf_ff[0];
   assign rsp_tlast = (left_ff == 3'd1);
   assign rsp_tuser = bad_ff;

endmodule

// ----- sv/xml_text_escaper_core.sv -----
// xml_text_escaper_core: top level of the xml text escaper
// depends on xte_pkg, xte_classify, xte_expand and xte_serial
//
// Escapes a byte stream for xml text, one source byte per req transfer.
// Each byte gives a run of 1 to 7 characters on rsp, one per transfer, with
// tlast on the run's last character: entities for quote, less-than,
// greater-than and ampersand, &#DDD; for bytes 127..255 and tab, newline and
// carriage return, the byte itself for other printable ascii, and '?' with
// tuser set for other control bytes. A zero byte gives a lone zero
// terminator; req_tlast on a nonzero byte appends one. A req transfer passes
// through the input register, classify stage, expand stage and output buffer
// before its first character appears. The output buffer sends one character
// per cycle while rsp_tready is high, so a byte that escapes to n characters
// holds back later bytes until all n are sent; plain bytes go one per cycle.
module xml_text_escaper_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // final_req
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,   // last_of_run
   output logic       rsp_tuser    // [0] bad_control
);

   logic             cls_valid, cls_ready;
   xte_pkg::cls_type cls_data;
   logic             seq_valid, seq_ready;
   xte_pkg::seq_type seq_data;

   xte_classify u_classify (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cls_valid  (cls_valid),
      .cls_ready  (cls_ready),
      .cls_data   (cls_data)
   );

   xte_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .cls_valid (cls_valid),
      .cls_ready (cls_ready),
      .cls_data  (cls_data),
      .seq_valid (seq_valid),
      .seq_ready (seq_ready),
      .seq_data  (seq_data)
   );

   xte_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .seq_valid  (seq_valid),
      .seq_ready  (seq_ready),
      .seq_data   (seq_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // a flagged control byte only ever yields '?' or its terminator
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata == "?" || rsp_tdata == 8'd0))
      else $error("bad control run carries unexpected character");

   // the terminator always closes its run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == 8'd0 |-> rsp_tlast)
      else $error("zero terminator not marked last");

   // a run continues without a gap once started
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a character run");

   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("output valid right after reset");

endmodule
